// ===== rtl/tbef_pkg.sv =====
`timescale 1ns / 1ps

package tbef_pkg;

    // Store geometry
    localparam int FLAG_COUNT = 64;
    localparam int FLAGS_PER_BYTE = 4;
    localparam int BYTE_COUNT = (FLAG_COUNT + FLAGS_PER_BYTE - 1) / FLAGS_PER_BYTE;

    // Field widths
    localparam int OP_W = 4;
    localparam int IDX_W = 6;
    localparam int ACTIVE_W = 5;
    localparam int ANSWER_W = 5;

    // Bytes a scan can ever reach: limited by the store and by the register range
    localparam int ACTIVE_MAX = (1 << ACTIVE_W) - 1;
    localparam int SCAN_BYTES = (BYTE_COUNT < ACTIVE_MAX) ? BYTE_COUNT : ACTIVE_MAX;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(16);

    // Flag encodings: bit 1 is the new bit, bit 0 the run bit
    localparam logic [1:0] FLAG_NUL = 2'b00;
    localparam logic [1:0] FLAG_RUN = 2'b01;
    localparam logic [1:0] FLAG_NEW = 2'b10;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR_ALL = 4'd0,
        OP_RESET     = 4'd1,
        OP_SET_NEW   = 4'd2,
        OP_GO_RUN    = 4'd3,
        OP_END       = 4'd4,
        OP_RETRY     = 4'd5,
        OP_IS_NEW    = 4'd6,
        OP_IS_RUN    = 4'd7,
        OP_IS_NUL    = 4'd8,
        OP_ANY_NEW   = 4'd9,
        OP_ANY_RUN   = 4'd10,
        OP_ANY_TAG   = 4'd11
    } op_t;

    // Outcome of a priority scan over the byte match vector
    typedef struct packed {
        logic                found;
        logic [ACTIVE_W-1:0] pos;
    } scan_result_t;

endpackage

// ===== rtl/two_bit_event_flag_bank.sv =====
`timescale 1ns / 1ps

// Two-bit event flag bank.
// Command channel (cmd_valid / cmd_stall) carries one word: operation and
// flag_index. Result channel (res_valid / res_stall) returns one answer word
// per command, in command order. A word moves on a clock edge where valid is
// high and stall is low.
// The accepting edge loads the input register; the answer register loads
// once the answer slot is free (no answer pending, or res_stall low).
// Throughput: one command per cycle unless res_stall holds an answer; every
// flag update and the 16-byte priority scan are combinational between the registers.
// When res_stall holds a pending answer, the command in the input register
// waits and cmd_stall rises; nothing is dropped.
// The user writes active_bytes via cfg_write / cfg_data only while idle; the
// block does not enforce it. Reset clears every flag to 00, sets active_bytes
// to 16 and empties both pipeline registers. No clearing pass is needed.
module two_bit_event_flag_bank
    import tbef_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [ACTIVE_W-1:0] cfg_data,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  logic [OP_W-1:0]     operation,
    input  logic [IDX_W-1:0]    flag_index,
    output logic                res_valid,
    input  logic                res_stall,
    output logic [ANSWER_W-1:0] answer
);

    logic [ACTIVE_W-1:0]             active_reg;
    logic [FLAG_COUNT-1:0][1:0]      flags_reg;
    logic [FLAG_COUNT-1:0][1:0]      flags_next;
    logic                            cmd_vld_reg;
    logic [OP_W-1:0]                 op_reg;
    logic [IDX_W-1:0]                idx_reg;
    logic                            res_vld_reg;
    logic [ANSWER_W-1:0]             answer_reg;
    logic [ANSWER_W-1:0]             answer_next;

    logic                            res_free;
    logic                            advance;
    op_t                             op;
    logic                            in_store;
    logic                            blocked;
    logic [1:0]                      cur_flag;
    logic                            flag_we;
    logic [1:0]                      flag_wval;
    logic                            clear_all;
    logic [SCAN_BYTES-1:0]           byte_new;
    logic [SCAN_BYTES-1:0]           byte_run;
    logic [SCAN_BYTES-1:0]           byte_on;
    logic [SCAN_BYTES-1:0]           match;
    scan_result_t                    scan_res;

    // Handshake: the held command moves on when the answer slot frees up
    assign res_free  = !res_vld_reg || !res_stall;
    assign advance   = cmd_vld_reg && res_free;
    assign cmd_stall = cmd_vld_reg && !res_free;
    assign res_valid = res_vld_reg;
    assign answer    = answer_reg;

    assign op = op_t'(op_reg);
    assign in_store = int'(idx_reg) < FLAG_COUNT;
    assign blocked = (active_reg != '0) && (active_reg <= {1'b0, idx_reg[IDX_W-1:2]});

    // Addressed flag; out-of-store indexes read as 00
    always_comb
    begin
        cur_flag = FLAG_NUL;
        for (int i = 0; i < FLAG_COUNT; i++)
        begin
            if (int'(idx_reg) == i)
            begin
                cur_flag = flags_reg[i];
            end
        end
    end

    // Per-byte summaries limited to the active window
    always_comb
    begin
        for (int b = 0; b < SCAN_BYTES; b++)
        begin
            byte_new[b] = 1'b0;
            byte_run[b] = 1'b0;
            for (int k = 0; k < FLAGS_PER_BYTE; k++)
            begin
                if (b * FLAGS_PER_BYTE + k < FLAG_COUNT)
                begin
                    byte_new[b] = byte_new[b] | flags_reg[b * FLAGS_PER_BYTE + k][1];
                    byte_run[b] = byte_run[b] | flags_reg[b * FLAGS_PER_BYTE + k][0];
                end
            end
            byte_on[b] = int'(active_reg) > b;
        end
    end

    always_comb
    begin
        case (op)
            OP_ANY_NEW: match = byte_new & byte_on;
            OP_ANY_RUN: match = byte_run & byte_on;
            default:    match = (byte_new | byte_run) & byte_on;
        endcase
    end

    tbef_scan u_scan
    (
        .match  (match),
        .result (scan_res)
    );

    // Operation decode: flag update and answer
    always_comb
    begin
        flag_we = 1'b0;
        flag_wval = FLAG_NUL;
        clear_all = 1'b0;
        answer_next = '0;
        case (op)
            OP_CLEAR_ALL:
            begin
                clear_all = 1'b1;
            end
            OP_RESET:
            begin
                flag_we = !blocked;
                flag_wval = FLAG_NUL;
            end
            OP_SET_NEW:
            begin
                flag_we = !blocked;
                flag_wval = cur_flag | FLAG_NEW;
            end
            OP_GO_RUN:
            begin
                if (!blocked && cur_flag == FLAG_NEW)
                begin
                    flag_we = 1'b1;
                    flag_wval = FLAG_RUN;
                    answer_next = ANSWER_W'(1);
                end
            end
            OP_END:
            begin
                if (!blocked && cur_flag[0])
                begin
                    flag_we = 1'b1;
                    flag_wval = cur_flag & FLAG_NEW;
                    answer_next = ANSWER_W'(1);
                end
            end
            OP_RETRY:
            begin
                if (!blocked && cur_flag[0])
                begin
                    flag_we = 1'b1;
                    flag_wval = FLAG_NEW;
                    answer_next = ANSWER_W'(1);
                end
            end
            OP_IS_NEW:
            begin
                answer_next = ANSWER_W'(!blocked && cur_flag[1]);
            end
            OP_IS_RUN:
            begin
                answer_next = ANSWER_W'(!blocked && cur_flag[0]);
            end
            OP_IS_NUL:
            begin
                answer_next = ANSWER_W'(blocked || cur_flag == FLAG_NUL);
            end
            OP_ANY_NEW, OP_ANY_RUN, OP_ANY_TAG:
            begin
                if (scan_res.found)
                begin
                    answer_next = active_reg - scan_res.pos;
                end
            end
            default:
            begin
                answer_next = '0;
            end
        endcase
    end

    // Next store contents; writes past the store are dropped
    always_comb
    begin
        flags_next = flags_reg;
        if (advance)
        begin
            if (clear_all)
            begin
                flags_next = '0;
            end
            else if (flag_we && in_store)
            begin
                for (int i = 0; i < FLAG_COUNT; i++)
                begin
                    if (int'(idx_reg) == i)
                    begin
                        flags_next[i] = flag_wval;
                    end
                end
            end
        end
    end

    // Control and store registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
            flags_reg <= '0;
            cmd_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                active_reg <= cfg_data;
            end
            flags_reg <= flags_next;
            if (!cmd_stall)
            begin
                cmd_vld_reg <= cmd_valid;
            end
            if (res_free)
            begin
                res_vld_reg <= cmd_vld_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            op_reg <= operation;
            idx_reg <= flag_index;
        end
        if (advance)
        begin
            answer_reg <= answer_next;
        end
    end

endmodule

// ===== rtl/tbef_scan.sv =====
`timescale 1ns / 1ps

// First matching byte, lowest position wins
module tbef_scan
    import tbef_pkg::*;
(
    input  logic [SCAN_BYTES-1:0] match,
    output scan_result_t          result
);

    always_comb
    begin
        result.found = |match;
        result.pos = '0;
        for (int b = SCAN_BYTES - 1; b >= 0; b--)
        begin
            if (match[b])
            begin
                result.pos = ACTIVE_W'(b);
            end
        end
    end

endmodule

// ===== rtl/tbef_check.sv =====
`timescale 1ns / 1ps

// Port-level checks for the flag bank
module tbef_check
    import tbef_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_stall,
    input logic [OP_W-1:0]     operation,
    input logic [IDX_W-1:0]    flag_index,
    input logic                res_valid,
    input logic                res_stall,
    input logic [ANSWER_W-1:0] answer
);

    // Commands are only held back by a stalled pending answer
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (res_valid && res_stall))
        else $error("cmd_stall without result backpressure");

    // An accepted word reaches the result port if res_stall is low while it is in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) ##1 !res_stall |=> res_valid)
        else $error("accepted word did not produce an answer");

    // The pipeline comes out of reset empty
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> (!res_valid && !cmd_stall))
        else $error("pipeline not empty after reset");

    // A stalled answer holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(answer)))
        else $error("stalled answer changed");

    // A stalled command word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_stall) |=>
            (cmd_valid && $stable(operation) && $stable(flag_index)))
        else $error("stalled command changed");

endmodule

bind two_bit_event_flag_bank tbef_check u_check (.*);
